// File: sv/oop_pkg.sv
// Shared types, constants and helper functions of the oscillator order parameter block.
// Used by the CORDIC unit, the magnitude unit and the top level; depends on nothing else.
package oop_pkg;

    localparam int MAX_NODES    = 1024;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);

    localparam int PHASE_W   = 16;
    localparam int MAG_W     = 16;
    localparam int ANG_OUT_W = 16;

    localparam int COUNT_W   = $clog2(MAX_NODES + 1);
    localparam int Q15_W     = 17;
    localparam int Q15_FRAC  = 15;
    localparam int Q15_ONE   = 32768;
    localparam int SUM_W     = $clog2(MAX_NODES) + Q15_W;
    localparam int ABS_W     = SUM_W - 1;
    localparam int SQ_W      = 2 * ABS_W;
    localparam int ROOT_W    = ABS_W;
    localparam int DIV_W     = ROOT_W + 1;
    localparam int CNT_W     = $clog2(DIV_W);

    localparam int VEC_SHIFT = 20;
    localparam int XY_W      = SUM_W + VEC_SHIFT + 2;

    localparam int ROT_GAIN_INV = 652032874;

    localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam logic [31:0] ANGLE_RND  = 32'(64'd1 << (31 - ANGLE_BITS));
    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0] QUARTER_RND = 32'h2000_0000;

    localparam logic signed [XY_W-1:0] Q15_RND  = XY_W'(1 << (Q15_FRAC - 1));
    localparam logic signed [XY_W-1:0] CLAMP_HI = XY_W'(Q15_ONE);
    localparam logic signed [XY_W-1:0] CLAMP_LO = -XY_W'(Q15_ONE);

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    typedef enum logic {
        CORDIC_ROTATE,
        CORDIC_VECTOR
    } t_cordic_mode;

    typedef struct packed {
        logic         start;
        t_cordic_mode mode;
    } t_cordic_ctrl;

    // Rounds a value at scale 2^30 to Q1.15 and clamps it to plus or minus one.
    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] r;
        r = (v + Q15_RND) >>> Q15_FRAC;
        if (r > CLAMP_HI) begin
            r = CLAMP_HI;
        end else if (r < CLAMP_LO) begin
            r = CLAMP_LO;
        end
        return Q15_W'(r);
    endfunction

endpackage

// File: sv/oop_cordic.sv
// Iterative CORDIC unit: one micro-rotation per cycle over a single add/shift datapath.
// Rotation mode gives Q1.15 cosine and sine; vectoring mode gives the angle. Uses oop_pkg.
module oop_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  oop_pkg::t_cordic_ctrl               i_ctrl,
    input  logic [31:0]                         i_angle,
    input  logic signed [oop_pkg::SUM_W-1:0]    i_cx,
    input  logic signed [oop_pkg::SUM_W-1:0]    i_sy,
    output logic                                o_busy,
    output logic signed [oop_pkg::Q15_W-1:0]    o_cos,
    output logic signed [oop_pkg::Q15_W-1:0]    o_sin,
    output logic [31:0]                         o_angle
);
    import oop_pkg::*;

    logic                    r_busy;
    t_cordic_mode            r_mode;
    logic [ITER_W-1:0]       r_iter;
    logic [1:0]              r_quad;
    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic [31:0]             r_z;

    logic [31:0]             rot_sum;
    logic [1:0]              rot_quad;
    logic [31:0]             rot_z;
    logic signed [XY_W-1:0]  vec_x;
    logic signed [XY_W-1:0]  vec_y;
    logic signed [XY_W-1:0]  shr_x;
    logic signed [XY_W-1:0]  shr_y;
    logic                    ccw;
    logic signed [XY_W-1:0]  post_x;
    logic signed [XY_W-1:0]  post_y;

    always_comb begin
        rot_sum  = i_angle + QUARTER_RND;
        rot_quad = rot_sum[31:30];
        rot_z    = i_angle - {rot_quad, 30'b0};
        vec_x    = XY_W'(i_cx) <<< VEC_SHIFT;
        vec_y    = XY_W'(i_sy) <<< VEC_SHIFT;
        shr_x    = r_x >>> r_iter;
        shr_y    = r_y >>> r_iter;
        ccw      = (r_mode == CORDIC_ROTATE) ? !r_z[31] : r_y[XY_W-1];
    end

    always_comb begin
        unique case (r_quad)
            2'd1: begin
                post_x = -r_y;
                post_y = r_x;
            end
            2'd2: begin
                post_x = -r_x;
                post_y = -r_y;
            end
            2'd3: begin
                post_x = r_y;
                post_y = -r_x;
            end
            default: begin
                post_x = r_x;
                post_y = r_y;
            end
        endcase
    end

    assign o_busy  = r_busy;
    assign o_cos   = to_q15(post_x);
    assign o_sin   = to_q15(post_y);
    assign o_angle = r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
            r_mode <= i_ctrl.mode;
            r_iter <= '0;
            if (i_ctrl.mode == CORDIC_ROTATE) begin
                r_x    <= XY_W'(ROT_GAIN_INV);
                r_y    <= '0;
                r_z    <= rot_z;
                r_quad <= rot_quad;
            end else begin
                r_quad <= '0;
                if (i_cx[SUM_W-1]) begin
                    r_x <= -vec_x;
                    r_y <= -vec_y;
                    r_z <= HALF_TURN;
                end else begin
                    r_x <= vec_x;
                    r_y <= vec_y;
                    r_z <= '0;
                end
            end
        end else if (r_busy) begin
            if (ccw) begin
                r_x <= r_x - shr_y;
                r_y <= r_y + shr_x;
                r_z <= r_z - ATAN_TAB[r_iter];
            end else begin
                r_x <= r_x + shr_y;
                r_y <= r_y - shr_x;
                r_z <= r_z + ATAN_TAB[r_iter];
            end
            r_iter <= r_iter + ITER_W'(1);
            if (r_iter == ITER_W'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// File: sv/oop_magnitude.sv
// Magnitude unit: shift-add squaring, digit-by-digit square root and restoring division,
// one step per cycle, giving the rounded mean-vector length in Q1.15. Uses oop_pkg.
module oop_magnitude (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [oop_pkg::ABS_W-1:0]     i_cos_abs,
    input  logic [oop_pkg::ABS_W-1:0]     i_sin_abs,
    input  logic [oop_pkg::COUNT_W-1:0]   i_count,
    output logic                          o_busy,
    output logic [oop_pkg::MAG_W-1:0]     o_magnitude
);
    import oop_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_SQ_C,
        M_SQ_S,
        M_ROOT,
        M_BIAS,
        M_DIV
    } t_mag_state;

    t_mag_state           r_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [SQ_W-1:0]      r_acc;
    logic [SQ_W-1:0]      r_mcand;
    logic [ABS_W-1:0]     r_mplier;
    logic [ABS_W-1:0]     r_sin_abs;
    logic [COUNT_W-1:0]   r_count;
    logic [SQ_W-1:0]      r_root;
    logic [SQ_W-1:0]      r_bit;
    logic [COUNT_W-1:0]   r_rem;
    logic [DIV_W-1:0]     r_dq;

    logic [SQ_W-1:0]      acc_sum;
    logic [SQ_W-1:0]      root_try;
    logic                 root_fits;
    logic [COUNT_W:0]     div_try;
    logic                 div_fits;
    logic [COUNT_W:0]     div_diff;
    logic                 sq_last;

    always_comb begin
        acc_sum   = r_mplier[0] ? (r_acc + r_mcand) : r_acc;
        root_try  = r_root + r_bit;
        root_fits = (r_acc >= root_try);
        div_try   = {r_rem, r_dq[DIV_W-1]};
        div_fits  = (div_try >= {1'b0, r_count});
        div_diff  = div_try - {1'b0, r_count};
        sq_last   = (r_cnt == CNT_W'(ABS_W - 1));
    end

    always_comb begin
        if (r_count == '0) begin
            o_magnitude = '0;
        end else if (r_dq > DIV_W'(Q15_ONE)) begin
            o_magnitude = MAG_W'(Q15_ONE);
        end else begin
            o_magnitude = r_dq[MAG_W-1:0];
        end
    end

    assign o_busy = (r_state != M_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_acc     <= '0;
                        r_mcand   <= SQ_W'(i_cos_abs);
                        r_mplier  <= i_cos_abs;
                        r_sin_abs <= i_sin_abs;
                        r_count   <= i_count;
                        r_cnt     <= '0;
                        r_state   <= M_SQ_C;
                    end
                end
                M_SQ_C: begin
                    r_acc <= acc_sum;
                    if (sq_last) begin
                        r_mcand  <= SQ_W'(r_sin_abs);
                        r_mplier <= r_sin_abs;
                        r_cnt    <= '0;
                        r_state  <= M_SQ_S;
                    end else begin
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                        r_cnt    <= r_cnt + CNT_W'(1);
                    end
                end
                M_SQ_S: begin
                    r_acc <= acc_sum;
                    if (sq_last) begin
                        r_root  <= '0;
                        r_bit   <= SQ_W'(1) << (SQ_W - 2);
                        r_cnt   <= '0;
                        r_state <= M_ROOT;
                    end else begin
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                        r_cnt    <= r_cnt + CNT_W'(1);
                    end
                end
                M_ROOT: begin
                    if (root_fits) begin
                        r_acc  <= r_acc - root_try;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                        r_state <= M_BIAS;
                    end
                end
                M_BIAS: begin
                    r_dq    <= DIV_W'(r_root[ROOT_W-1:0]) + DIV_W'(r_count >> 1);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= M_DIV;
                end
                M_DIV: begin
                    r_rem <= div_fits ? div_diff[COUNT_W-1:0] : div_try[COUNT_W-1:0];
                    r_dq  <= {r_dq[DIV_W-2:0], div_fits};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_W - 1)) begin
                        r_state <= M_IDLE;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/oscillator_order_parameter.sv
// Order parameter of a set of oscillator phases; instantiates oop_cordic and oop_magnitude.
// A phase is accepted only in the idle state; it runs the shared CORDIC iterations and is
// accumulated before the next one is taken, while a phase beyond the node limit only sets
// the overflow flag. A set's result enters the output register once the vectoring CORDIC and
// the magnitude unit are done and the register is free, and waits there until the receiver takes it.
// Synchronous active-low reset clears the sums, the count, the overflow flag and all valids.
module oscillator_order_parameter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] phase_angle
    input  logic        i_s_tlast,   // last_phase
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] order_magnitude, [31:16] mean_angle
    output logic        o_m_tuser    // set_overflow
);
    import oop_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_FIN,
        S_WAIT
    } t_top_state;

    t_top_state                r_state;
    logic                      r_last;
    logic signed [SUM_W-1:0]   r_cos_sum;
    logic signed [SUM_W-1:0]   r_sin_sum;
    logic [COUNT_W-1:0]        r_count;
    logic                      r_overflow;
    logic                      r_out_valid;
    logic [MAG_W-1:0]          r_out_mag;
    logic [ANG_OUT_W-1:0]      r_out_angle;
    logic                      r_out_ovf;

    logic                      s_accept;
    logic                      not_full;
    logic [31:0]               phase_bam;
    t_cordic_ctrl              cordic_ctrl;
    logic                      cordic_busy;
    logic signed [Q15_W-1:0]   cordic_cos;
    logic signed [Q15_W-1:0]   cordic_sin;
    logic [31:0]               cordic_angle;
    logic                      mag_busy;
    logic [MAG_W-1:0]          mag_value;
    logic [ABS_W-1:0]          cos_abs;
    logic [ABS_W-1:0]          sin_abs;
    logic [31:0]               ang_rnd;
    logic [31:0]               ang_full;
    logic                      sums_zero;
    logic                      out_free;
    logic                      out_load;

    always_comb begin
        s_accept  = i_s_tvalid && (r_state == S_IDLE);
        not_full  = (r_count < COUNT_W'(MAX_NODES));
        phase_bam = (32'(i_s_tdata[PHASE_W-1:0]) & ANGLE_MASK) << (32 - ANGLE_BITS);
        cordic_ctrl.start = (s_accept && not_full) || (r_state == S_FIN);
        cordic_ctrl.mode  = (r_state == S_FIN) ? CORDIC_VECTOR : CORDIC_ROTATE;
        cos_abs   = r_cos_sum[SUM_W-1] ? ABS_W'(-r_cos_sum) : ABS_W'(r_cos_sum);
        sin_abs   = r_sin_sum[SUM_W-1] ? ABS_W'(-r_sin_sum) : ABS_W'(r_sin_sum);
        ang_rnd   = cordic_angle + ANGLE_RND;
        ang_full  = ang_rnd >> (32 - ANGLE_BITS);
        sums_zero = (r_cos_sum == '0) && (r_sin_sum == '0);
        out_free  = !r_out_valid || i_m_tready;
        out_load  = (r_state == S_WAIT) && !cordic_busy && !mag_busy && out_free;
    end

    oop_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cordic_ctrl),
        .i_angle (phase_bam),
        .i_cx    (r_cos_sum),
        .i_sy    (r_sin_sum),
        .o_busy  (cordic_busy),
        .o_cos   (cordic_cos),
        .o_sin   (cordic_sin),
        .o_angle (cordic_angle)
    );

    oop_magnitude u_magnitude (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_FIN),
        .i_cos_abs   (cos_abs),
        .i_sin_abs   (sin_abs),
        .i_count     (r_count),
        .o_busy      (mag_busy),
        .o_magnitude (mag_value)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_angle, r_out_mag};
    assign o_m_tuser  = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_cos_sum   <= '0;
            r_sin_sum   <= '0;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_last <= i_s_tlast;
                        if (not_full) begin
                            r_state <= S_ROT;
                        end else begin
                            r_overflow <= 1'b1;
                            if (i_s_tlast) begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_ROT: begin
                    if (!cordic_busy) begin
                        r_cos_sum <= r_cos_sum + SUM_W'(cordic_cos);
                        r_sin_sum <= r_sin_sum + SUM_W'(cordic_sin);
                        r_count   <= r_count + COUNT_W'(1);
                        r_state   <= r_last ? S_FIN : S_IDLE;
                    end
                end
                S_FIN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (out_load) begin
                        r_out_mag   <= mag_value;
                        r_out_angle <= sums_zero ? '0 : ang_full[ANG_OUT_W-1:0];
                        r_out_ovf   <= r_overflow;
                        r_cos_sum   <= '0;
                        r_sin_sum   <= '0;
                        r_count     <= '0;
                        r_overflow  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
